[hw/rtl/csv_pkg.sv]
// ----------------------------------------------------------------------------
// csv_pkg
// Types, constants and small tables shared by the clock-set frame validator.
// ----------------------------------------------------------------------------
package csv_pkg;

    localparam int ID_W     = 11;
    localparam int YEAR_W   = 14;
    localparam int YFULL_W  = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 14;
    localparam int JDN_W    = 24;

    localparam logic [7:0] RESP_OK  = 8'h55;
    localparam logic [7:0] RESP_ERR = 8'hAA;

    localparam logic [YFULL_W-1:0] YEAR_BIAS  = 15'd4800;
    localparam logic [JDN_W-1:0]   JDN_OFFSET = 24'd32044;

    typedef enum logic [1:0] {
        KIND_TIME  = 2'd0,
        KIND_DATE  = 2'd1,
        KIND_ALARM = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_ID    = 3'd0,
        CFG_DATE_ID    = 3'd1,
        CFG_ALARM_ID   = 3'd2,
        CFG_YEAR_LOWER = 3'd3,
        CFG_YEAR_UPPER = 3'd4
    } t_cfg_index;

    // Days in each month of a common year, indexed by month number.
    localparam logic [4:0] MONTH_DAYS [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    // Day offset (153 * mm + 2) / 5 of the month in a year that starts in March.
    localparam logic [8:0] MONTH_OFFSET [16] = '{
        9'd0, 9'd306, 9'd337, 9'd0, 9'd31, 9'd61, 9'd92, 9'd122,
        9'd153, 9'd184, 9'd214, 9'd245, 9'd275, 9'd0, 9'd0, 9'd0
    };

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         response_code;
        logic [4:0]         hour_value;
        logic [5:0]         minute_value;
        logic [5:0]         second_value;
        logic [4:0]         day_value;
        logic [3:0]         month_value;
        logic [YEAR_W-1:0]  year_value;
        logic [2:0]         weekday_value;
    } t_result;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] p1;
        logic [7:0] p2;
        logic [7:0] p3;
        logic [7:0] p4;
    } t_s1;

    typedef struct packed {
        t_kind               kind;
        logic [7:0]          p1;
        logic [7:0]          p2;
        logic [7:0]          p3;
        logic [YFULL_W-1:0]  year;
        logic                hm_ok;
        logic                sec_ok;
        logic                mon_ok;
        logic [4:0]          lim;
        logic                early;
        logic [8:0]          moff;
        logic                p4r_zero;
        logic [7:0]          cent;
    } t_s2;

    typedef struct packed {
        t_result     res;
        logic        date_ok;
        logic [22:0] m365;
        logic [12:0] yq;
        logic [7:0]  hc;
        logic [4:0]  day;
        logic [8:0]  moff;
    } t_s3;

    typedef struct packed {
        t_result           res;
        logic              date_ok;
        logic [JDN_W-1:0]  jdn;
    } t_s4;

    function automatic logic [7:0] bcd_value(input logic [7:0] b);
        return (8'(b[7:4]) * 8'd10) + 8'(b[3:0]);
    endfunction

endpackage

[hw/rtl/csv_frame_if.sv]
// ----------------------------------------------------------------------------
// csv_frame_if
// Channel that carries one received single-frame message per item.
// ----------------------------------------------------------------------------
interface csv_frame_if;
    import csv_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   frame_id;
    logic [7:0]        pci_byte;
    logic [7:0]        param_byte_one;
    logic [7:0]        param_byte_two;
    logic [7:0]        param_byte_three;
    logic [7:0]        param_byte_four;

    modport source (
        output valid, frame_id, pci_byte, param_byte_one, param_byte_two,
               param_byte_three, param_byte_four,
        input  ready
    );
    modport sink (
        input  valid, frame_id, pci_byte, param_byte_one, param_byte_two,
               param_byte_three, param_byte_four,
        output ready
    );
endinterface

[hw/rtl/csv_result_if.sv]
// ----------------------------------------------------------------------------
// csv_result_if
// Channel that carries one validation response per item.
// ----------------------------------------------------------------------------
interface csv_result_if;
    import csv_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         message_kind;
    logic [7:0]         response_code;
    logic [4:0]         hour_value;
    logic [5:0]         minute_value;
    logic [5:0]         second_value;
    logic [4:0]         day_value;
    logic [3:0]         month_value;
    logic [YEAR_W-1:0]  year_value;
    logic [2:0]         weekday_value;

    modport source (
        output valid, message_kind, response_code, hour_value, minute_value,
               second_value, day_value, month_value, year_value, weekday_value,
        input  ready
    );
    modport sink (
        input  valid, message_kind, response_code, hour_value, minute_value,
               second_value, day_value, month_value, year_value, weekday_value,
        output ready
    );
endinterface

[hw/rtl/csv_cfg_if.sv]
// ----------------------------------------------------------------------------
// csv_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface csv_cfg_if;
    import csv_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DAT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/clock_set_frame_validator.sv]
// ----------------------------------------------------------------------------
// clock_set_frame_validator
// Checks received time, date and alarm set frames and returns a response
// with the decoded values and, for dates, the weekday.
//
//   Channel   Direction  Item
//   i_frame   in         frame_id, pci_byte, four BCD parameter bytes
//   o_result  out        kind, response code, decoded values, weekday
//   i_cfg     in         register index and data, always ready
//
// One item per cycle is taken while o_result is not stalled.
// Frames that fail the control byte or identifier checks give no result.
// Reset clears all stage valid bits and loads the register defaults.
// A stall on o_result holds each full stage whose later stages are all full; the others still advance and fill.
// ----------------------------------------------------------------------------
module clock_set_frame_validator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csv_frame_if.sink     i_frame,
    csv_result_if.source  o_result,
    csv_cfg_if.sink       i_cfg
);
    import csv_pkg::*;

    logic [ID_W-1:0]   r_time_msg_id;
    logic [ID_W-1:0]   r_date_msg_id;
    logic [ID_W-1:0]   r_alarm_msg_id;
    logic [YEAR_W-1:0] r_year_lower_bound;
    logic [YEAR_W-1:0] r_year_upper_bound;

    logic    w_v2;
    logic    w_rdy3;
    t_s2     w_s2;
    logic    w_v3;
    logic    w_rdy4;
    t_s3     w_s3;
    t_result w_res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_msg_id      <= 11'd273;
            r_date_msg_id      <= 11'd289;
            r_alarm_msg_id     <= 11'd257;
            r_year_lower_bound <= 14'd1901;
            r_year_upper_bound <= 14'd2099;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TIME_ID:    r_time_msg_id      <= i_cfg.data[ID_W-1:0];
                CFG_DATE_ID:    r_date_msg_id      <= i_cfg.data[ID_W-1:0];
                CFG_ALARM_ID:   r_alarm_msg_id     <= i_cfg.data[ID_W-1:0];
                CFG_YEAR_LOWER: r_year_lower_bound <= i_cfg.data[YEAR_W-1:0];
                CFG_YEAR_UPPER: r_year_upper_bound <= i_cfg.data[YEAR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    csv_decode u_decode (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_frame.valid),
        .o_ready            (i_frame.ready),
        .i_frame_id         (i_frame.frame_id),
        .i_pci_byte         (i_frame.pci_byte),
        .i_param_byte_one   (i_frame.param_byte_one),
        .i_param_byte_two   (i_frame.param_byte_two),
        .i_param_byte_three (i_frame.param_byte_three),
        .i_param_byte_four  (i_frame.param_byte_four),
        .i_time_msg_id      (r_time_msg_id),
        .i_date_msg_id      (r_date_msg_id),
        .i_alarm_msg_id     (r_alarm_msg_id),
        .o_valid            (w_v2),
        .i_ready            (w_rdy3),
        .o_s2               (w_s2)
    );

    csv_check u_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (w_v2),
        .o_ready            (w_rdy3),
        .i_s2               (w_s2),
        .i_year_lower_bound (r_year_lower_bound),
        .i_year_upper_bound (r_year_upper_bound),
        .o_valid            (w_v3),
        .i_ready            (w_rdy4),
        .o_s3               (w_s3)
    );

    csv_weekday u_weekday (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v3),
        .o_ready (w_rdy4),
        .i_s3    (w_s3),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_res   (w_res)
    );

    assign o_result.message_kind  = w_res.kind;
    assign o_result.response_code = w_res.response_code;
    assign o_result.hour_value    = w_res.hour_value;
    assign o_result.minute_value  = w_res.minute_value;
    assign o_result.second_value  = w_res.second_value;
    assign o_result.day_value     = w_res.day_value;
    assign o_result.month_value   = w_res.month_value;
    assign o_result.year_value    = w_res.year_value;
    assign o_result.weekday_value = w_res.weekday_value;
endmodule

[hw/rtl/csv_decode.sv]
// ----------------------------------------------------------------------------
// csv_decode
// Stages one and two: frame filter, identifier match and BCD decode, then
// year assembly and the checks that need no year.
// ----------------------------------------------------------------------------
module csv_decode (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [csv_pkg::ID_W-1:0] i_frame_id,
    input  logic [7:0]             i_pci_byte,
    input  logic [7:0]             i_param_byte_one,
    input  logic [7:0]             i_param_byte_two,
    input  logic [7:0]             i_param_byte_three,
    input  logic [7:0]             i_param_byte_four,
    input  logic [csv_pkg::ID_W-1:0] i_time_msg_id,
    input  logic [csv_pkg::ID_W-1:0] i_date_msg_id,
    input  logic [csv_pkg::ID_W-1:0] i_alarm_msg_id,
    output logic                   o_valid,
    input  logic                   i_ready,
    output csv_pkg::t_s2           o_s2
);
    import csv_pkg::*;

    logic  r_v1;
    t_s1   r_s1;
    logic  r_v2;
    t_s2   r_s2;
    logic  w_rdy1;
    logic  w_rdy2;
    logic  w_pass;
    t_s1   n_s1;
    t_s2   n_s2;
    logic  w_p4_big;
    logic [7:0] w_p4r;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_s2    = r_s2;

    always_comb begin
        w_pass    = (i_pci_byte[7:4] == 4'd0) && !i_pci_byte[3] && (i_pci_byte[2:0] != 3'd0);
        n_s1.kind = KIND_TIME;
        if (i_frame_id == i_time_msg_id) begin
            n_s1.kind = KIND_TIME;
        end else if (i_frame_id == i_date_msg_id) begin
            n_s1.kind = KIND_DATE;
        end else if (i_frame_id == i_alarm_msg_id) begin
            n_s1.kind = KIND_ALARM;
        end else begin
            w_pass = 1'b0;
        end
        n_s1.p1 = bcd_value(i_param_byte_one);
        n_s1.p2 = bcd_value(i_param_byte_two);
        n_s1.p3 = bcd_value(i_param_byte_three);
        n_s1.p4 = bcd_value(i_param_byte_four);
    end

    always_comb begin
        w_p4_big      = r_s1.p4 >= 8'd100;
        w_p4r         = w_p4_big ? (r_s1.p4 - 8'd100) : r_s1.p4;
        n_s2.kind     = r_s1.kind;
        n_s2.p1       = r_s1.p1;
        n_s2.p2       = r_s1.p2;
        n_s2.p3       = r_s1.p3;
        n_s2.year     = (YFULL_W'(r_s1.p3) * YFULL_W'(100)) + YFULL_W'(r_s1.p4);
        n_s2.hm_ok    = (r_s1.p1 < 8'd24) && (r_s1.p2 < 8'd60);
        n_s2.sec_ok   = r_s1.p3 < 8'd60;
        n_s2.mon_ok   = (r_s1.p2 >= 8'd1) && (r_s1.p2 <= 8'd12);
        n_s2.lim      = MONTH_DAYS[r_s1.p2[3:0]];
        n_s2.early    = (r_s1.p2 == 8'd1) || (r_s1.p2 == 8'd2);
        n_s2.moff     = MONTH_OFFSET[r_s1.p2[3:0]];
        n_s2.p4r_zero = w_p4r == 8'd0;
        n_s2.cent     = r_s1.p3 + 8'(w_p4_big);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid && w_pass;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1 <= n_s1;
        end
        if (w_rdy2) begin
            r_s2 <= n_s2;
        end
    end
endmodule

[hw/rtl/csv_check.sv]
// ----------------------------------------------------------------------------
// csv_check
// Stage three: leap year, day and year bound checks, response fields and the
// year terms of the Julian day number.
// ----------------------------------------------------------------------------
module csv_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  csv_pkg::t_s2                i_s2,
    input  logic [csv_pkg::YEAR_W-1:0]  i_year_lower_bound,
    input  logic [csv_pkg::YEAR_W-1:0]  i_year_upper_bound,
    output logic                        o_valid,
    input  logic                        i_ready,
    output csv_pkg::t_s3                o_s3
);
    import csv_pkg::*;

    logic  r_v3;
    t_s3   r_s3;
    t_s3   n_s3;
    logic  w_rdy3;
    logic  w_leap;
    logic [4:0] w_lim;
    logic  w_date_ok;
    logic  w_ok;
    logic [YFULL_W-1:0] w_yy;

    assign w_rdy3  = !r_v3 || i_ready;
    assign o_ready = w_rdy3;
    assign o_valid = r_v3;
    assign o_s3    = r_s3;

    always_comb begin
        w_leap    = i_s2.p4r_zero ? (i_s2.cent[1:0] == 2'd0) : (i_s2.year[1:0] == 2'd0);
        w_lim     = ((i_s2.p2 == 8'd2) && w_leap) ? 5'd29 : i_s2.lim;
        w_date_ok = i_s2.mon_ok && (i_s2.p1 >= 8'd1) && (i_s2.p1 <= 8'(w_lim))
                    && (i_s2.year >= YFULL_W'(i_year_lower_bound))
                    && (i_s2.year <= YFULL_W'(i_year_upper_bound));
        w_yy      = i_s2.year + YEAR_BIAS - YFULL_W'(i_s2.early);

        n_s3 = '0;
        n_s3.res.kind = i_s2.kind;
        case (i_s2.kind)
            KIND_TIME: begin
                w_ok = i_s2.hm_ok && i_s2.sec_ok;
                if (w_ok) begin
                    n_s3.res.hour_value   = i_s2.p1[4:0];
                    n_s3.res.minute_value = i_s2.p2[5:0];
                    n_s3.res.second_value = i_s2.p3[5:0];
                end
            end
            KIND_ALARM: begin
                w_ok = i_s2.hm_ok;
                if (w_ok) begin
                    n_s3.res.hour_value   = i_s2.p1[4:0];
                    n_s3.res.minute_value = i_s2.p2[5:0];
                end
            end
            KIND_DATE: begin
                w_ok = w_date_ok;
                if (w_ok) begin
                    n_s3.res.day_value   = i_s2.p1[4:0];
                    n_s3.res.month_value = i_s2.p2[3:0];
                    n_s3.res.year_value  = i_s2.year[YEAR_W-1:0];
                end
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
        n_s3.res.response_code = w_ok ? RESP_OK : RESP_ERR;
        n_s3.date_ok = w_ok && (i_s2.kind == KIND_DATE);
        n_s3.m365    = 23'(w_yy) * 23'd365;
        n_s3.yq      = w_yy[YFULL_W-1:2];
        n_s3.hc      = 8'd48 + i_s2.cent - 8'(i_s2.early && i_s2.p4r_zero);
        n_s3.day     = i_s2.p1[4:0];
        n_s3.moff    = i_s2.moff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3 <= n_s3;
        end
    end
endmodule

[hw/rtl/csv_weekday.sv]
// ----------------------------------------------------------------------------
// csv_weekday
// Stages four and five: Julian day number sum, then its remainder by seven
// by folding octal digits, into the output register.
// ----------------------------------------------------------------------------
module csv_weekday (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  csv_pkg::t_s3     i_s3,
    output logic             o_valid,
    input  logic             i_ready,
    output csv_pkg::t_result o_res
);
    import csv_pkg::*;

    logic     r_v4;
    t_s4      r_s4;
    logic     r_v5;
    t_result  r_res;
    t_s4      n_s4;
    t_result  n_res;
    logic     w_rdy4;
    logic     w_rdy5;
    logic [5:0] w_dsum;
    logic [3:0] w_fold;
    logic [2:0] w_wday;

    assign w_rdy5  = !r_v5 || i_ready;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign o_ready = w_rdy4;
    assign o_valid = r_v5;
    assign o_res   = r_res;

    always_comb begin
        n_s4.res     = i_s3.res;
        n_s4.date_ok = i_s3.date_ok;
        n_s4.jdn     = JDN_W'(i_s3.m365) + JDN_W'(i_s3.yq) + JDN_W'(i_s3.hc[7:2])
                       + JDN_W'(i_s3.day) + JDN_W'(i_s3.moff)
                       - JDN_W'(i_s3.hc) - JDN_OFFSET;
    end

    always_comb begin
        w_dsum = '0;
        for (int k = 0; k < JDN_W / 3; k++) begin
            w_dsum = w_dsum + 6'(r_s4.jdn[3*k +: 3]);
        end
        w_fold = 4'(w_dsum[5:3]) + 4'(w_dsum[2:0]);
        if (w_fold >= 4'd14) begin
            w_wday = 3'(w_fold - 4'd14);
        end else if (w_fold >= 4'd7) begin
            w_wday = 3'(w_fold - 4'd7);
        end else begin
            w_wday = w_fold[2:0];
        end
        n_res = r_s4.res;
        n_res.weekday_value = r_s4.date_ok ? w_wday : 3'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy4) begin
                r_v4 <= i_valid;
            end
            if (w_rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_s4 <= n_s4;
        end
        if (w_rdy5) begin
            r_res <= n_res;
        end
    end
endmodule
